// ===== hw/rtl/bbld_pkg.sv =====
// Shared types and constants for the beam-break level detector.
package bbld_pkg;

  localparam int NUM_LEVELS = 10;
  localparam int LEVEL_W    = 4;
  localparam int CNT_W      = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Word commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  // Report modes; the last code behaves as the quiet one
  localparam logic [1:0] MODE_ON_BLOCK   = 2'd0;
  localparam logic [1:0] MODE_ON_RECOVER = 2'd1;
  localparam logic [1:0] MODE_QUIET      = 2'd2;
  localparam logic [1:0] MODE_SPARE      = 2'd3;

  // Event kinds
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_REPORT = 2'd1;
  localparam logic [1:0] EV_BLOCK  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_PERIOD    = 3'd4;

  typedef struct packed {
    logic [15:0] block_threshold;
    logic [1:0]  report_mode;
    logic [7:0]  recover_count;
    logic [9:0]  blink_period;
    logic [3:0]  burst_period;
  } cfg_t;

  typedef struct packed {
    logic               carrier_on;
    logic [LEVEL_W-1:0] emit_level;
    logic               beat_led;
    logic               armed_beat_led;
    logic [1:0]         event_kind;
    logic [LEVEL_W-1:0] event_level;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/bbld_core.sv =====
// Detector state and per-word update: heartbeat, carrier gating, blockage qualifier.
module bbld_core import bbld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  cmd,
  input  logic [LEVEL_W-1:0]    arm_level,
  input  logic [NUM_LEVELS-1:0] receiver_bits,
  input  cfg_t                  cfg,
  output result_t               res
);

  logic [9:0]         blink_count, blink_count_next;
  logic [3:0]         burst_phase, burst_phase_next;
  logic [LEVEL_W-1:0] armed_level, armed_level_next;
  logic               blocked_seen, blocked_seen_next;
  logic [CNT_W-1:0]   blocked_count, blocked_count_next;
  logic [CNT_W-1:0]   recovered_count, recovered_count_next;
  logic               green_led, green_led_next;
  logic               blue_led, blue_led_next;

  logic [9:0]         blink_inc;
  logic [3:0]         phase_inc;
  logic [LEVEL_W-1:0] rx_idx;
  logic               rx;
  logic               block_hit;
  logic               gate_off;
  logic               carrier;

  always_comb begin
    blink_count_next     = blink_count;
    burst_phase_next     = burst_phase;
    armed_level_next     = armed_level;
    blocked_seen_next    = blocked_seen;
    blocked_count_next   = blocked_count;
    recovered_count_next = recovered_count;
    green_led_next       = green_led;
    blue_led_next        = blue_led;
    blink_inc            = blink_count + 10'd1;
    phase_inc            = burst_phase + 4'd1;
    rx_idx               = armed_level - LEVEL_W'(1);
    rx                   = receiver_bits[rx_idx];
    block_hit            = 1'b0;
    gate_off             = 1'b0;
    carrier              = 1'b0;
    res                  = '0;

    if (cmd == CMD_ARM) begin
      // Out-of-range levels leave the armed level alone
      if (arm_level <= LEVEL_W'(NUM_LEVELS)) begin
        armed_level_next = arm_level;
      end
    end else begin
      blink_count_next = blink_inc;
      if (blink_inc == cfg.blink_period) begin
        green_led_next = ~green_led;
        if (armed_level != '0) begin
          blue_led_next = ~blue_led;
        end
        blink_count_next = '0;
      end

      if (armed_level != '0) begin
        carrier          = (phase_inc == 4'd1);
        burst_phase_next = (phase_inc == cfg.burst_period) ? 4'd0 : phase_inc;

        if (rx) begin
          if (!blocked_seen) begin
            blocked_count_next = '0;
          end else begin
            recovered_count_next = sat_inc(recovered_count);
          end
        end else if (!blocked_seen) begin
          blocked_count_next = sat_inc(blocked_count);
        end

        block_hit = !blocked_seen && (blocked_count_next > cfg.block_threshold);
        if (block_hit) begin
          blocked_count_next   = '0;
          recovered_count_next = '0;
          if (cfg.report_mode == MODE_ON_BLOCK) begin
            res.event_kind   = EV_REPORT;
            res.event_level  = armed_level;
            armed_level_next = '0;
          end else if (cfg.report_mode == MODE_ON_RECOVER) begin
            blocked_seen_next = 1'b1;
            res.event_kind    = EV_BLOCK;
            res.event_level   = armed_level;
          end
          gate_off         = 1'b1;
          burst_phase_next = '0;
        end

        // Recovery check sees the counts as updated above
        if (cfg.report_mode == MODE_ON_RECOVER && blocked_seen_next &&
            recovered_count_next >= CNT_W'(cfg.recover_count)) begin
          res.event_kind       = EV_REPORT;
          res.event_level      = armed_level;
          armed_level_next     = '0;
          blocked_seen_next    = 1'b0;
          blocked_count_next   = '0;
          recovered_count_next = '0;
          gate_off             = 1'b1;
          burst_phase_next     = '0;
        end

        res.carrier_on = carrier && !gate_off;
        res.emit_level = res.carrier_on ? armed_level : '0;
      end
    end

    res.beat_led       = green_led_next;
    res.armed_beat_led = blue_led_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count     <= '0;
      burst_phase     <= '0;
      armed_level     <= '0;
      blocked_seen    <= 1'b0;
      blocked_count   <= '0;
      recovered_count <= '0;
      green_led       <= 1'b0;
      blue_led        <= 1'b0;
    end else if (en) begin
      blink_count     <= blink_count_next;
      burst_phase     <= burst_phase_next;
      armed_level     <= armed_level_next;
      blocked_seen    <= blocked_seen_next;
      blocked_count   <= blocked_count_next;
      recovered_count <= recovered_count_next;
      green_led       <= green_led_next;
      blue_led        <= blue_led_next;
    end
  end

endmodule

// ===== hw/rtl/beam_break_level_detector_unit.sv =====
// Beam-break level detector top level: input register, detector core, result register.
//
// Each input word (a millisecond tick or an arm command) yields exactly one result word.
// A word is taken into an input register and processed by the detector core, which loads
// its result into an output register; the block sustains one word per clock while the
// output side does not stall. A word's result is held in the output register until the
// output side takes it. The input stalls only while both registers are full and the output
// is stalled. The configuration port is always ready; write it only while no words are in
// flight.
module beam_break_level_detector_unit import bbld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [LEVEL_W-1:0]    arm_level,
  input  logic [NUM_LEVELS-1:0] receiver_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  carrier_on,
  output logic [LEVEL_W-1:0]    emit_level,
  output logic                  beat_led,
  output logic                  armed_beat_led,
  output logic [1:0]            event_kind,
  output logic [LEVEL_W-1:0]    event_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  cfg_t cfg;

  logic                  s1_valid;
  logic                  s1_cmd;
  logic [LEVEL_W-1:0]    s1_level;
  logic [NUM_LEVELS-1:0] s1_rx;

  logic    out_free;
  logic    s1_fire;
  result_t res;
  result_t out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_threshold <= 16'd20;
      cfg.report_mode     <= MODE_ON_BLOCK;
      cfg.recover_count   <= 8'd6;
      cfg.blink_period    <= 10'd500;
      cfg.burst_period    <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_THRESHOLD: cfg.block_threshold <= cfg_data;
        REG_REPORT_MODE:     cfg.report_mode     <= cfg_data[1:0];
        REG_RECOVER_COUNT:   cfg.recover_count   <= cfg_data[7:0];
        REG_BLINK_PERIOD:    cfg.blink_period    <= cfg_data[9:0];
        REG_BURST_PERIOD:    cfg.burst_period    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result register is empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd   <= cmd;
      s1_level <= arm_level;
      s1_rx    <= receiver_bits;
    end
  end

  bbld_core u_core (
    .clk           (clk),
    .rst           (rst),
    .en            (s1_fire),
    .cmd           (s1_cmd),
    .arm_level     (s1_level),
    .receiver_bits (s1_rx),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word <= res;
    end
  end

  assign carrier_on     = out_word.carrier_on;
  assign emit_level     = out_word.emit_level;
  assign beat_led       = out_word.beat_led;
  assign armed_beat_led = out_word.armed_beat_led;
  assign event_kind     = out_word.event_kind;
  assign event_level    = out_word.event_level;

endmodule
